/* design/i2cbms_pkg.sv */
package i2cbms_pkg;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_S0   = 5'b00010,
		PH_S1   = 5'b00100,
		PH_S2   = 5'b01000,
		PH_S3   = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_STOP      = 3'd2,
		CMD_WRITE     = 3'd3,
		CMD_READ      = 3'd4,
		CMD_ACK_CHECK = 3'd5,
		CMD_SEND_ACK  = 3'd6,
		CMD_SEND_NACK = 3'd7
	} cmd_t;

	typedef struct packed {
		logic scl_lvl;
		logic scl_drv;
		logic sda_lvl;
		logic sda_drv;
	} pins_t;

	typedef struct packed {
		phase_t      phase;
		cmd_t        cmd;
		logic [9:0]  delay;
		logic [3:0]  bits;
		logic [7:0]  shift;
		pins_t       pins;
		logic        ack;
		logic        done;
		logic        fin_read;
	} seq_t;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] TICKS_RESET   = 8'd8;
	localparam logic [9:0] SCL_HIGH_READ = 10'd1;

endpackage

/* design/i2c_byte_master_sequencer.sv */
// I2C byte-level master sequencer, one input word per bus timing tick.
// Input channel (in_valid/in_ready): action, write_byte, sda_level. Each word
// is one tick; a command in action is taken only when no command is running,
// otherwise it is ignored. Output channel (out_valid/out_ready): one result
// word per input word with the pin levels and enables, busy, a done pulse,
// the read byte on the done word of a read, and the last ack check level.
// A result word passes through an input register, then a result register.
// Throughput: one word per cycle while out_ready is high; the
// sequencer state, a chain of at most three phase steps, updates as a
// word moves from the input register into the result register.
// Bus waits are counted in words: one delay unit is ticks_per_microsecond
// words, set by cfg_wr_en/cfg_wr_data; the user writes it only while no command
// runs; the block does not enforce it. Reset: both lines released, sequencer idle,
// unit length 8, no word held. When out_ready is low the result register holds,
// the input register fills, then in_ready drops; no word is lost or repeated.
module i2c_byte_master_sequencer
	import i2cbms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [7:0] write_byte,
	input  logic       sda_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       scl_drive,
	output logic       sda_out_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_byte,
	output logic       ack_level
);

	logic [7:0] ticks_q;

	logic       valid_s1;
	logic [2:0] action_s1;
	logic [7:0] wbyte_s1;
	logic       sda_s1;

	logic       valid_s2;
	pins_t      pins_s2;
	logic       busy_s2;
	logic       done_s2;
	logic [7:0] rbyte_s2;
	logic       ack_s2;

	seq_t       state_q;
	seq_t       front;
	seq_t       st1;
	seq_t       st2;
	seq_t       st3;
	logic       adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wr_data;
		end
	end

	// tick front end: command take or delay countdown
	always_comb begin
		front = state_q;
		front.done = 1'b0;
		front.fin_read = 1'b0;
		if (state_q.phase == PH_IDLE) begin
			if (cmd_t'(action_s1) != CMD_NONE) begin
				front.cmd = cmd_t'(action_s1);
				front.phase = PH_S0;
				front.delay = 10'd0;
				if (cmd_t'(action_s1) == CMD_WRITE) begin
					front.shift = wbyte_s1;
				end
			end
		end else if (state_q.delay != 10'd0) begin
			front.delay = state_q.delay - 10'd1;
		end
	end

	i2cbms_step u_step1 (.cur(front), .tpu(ticks_q), .sda(sda_s1), .nxt(st1));
	i2cbms_step u_step2 (.cur(st1),   .tpu(ticks_q), .sda(sda_s1), .nxt(st2));
	i2cbms_step u_step3 (.cur(st2),   .tpu(ticks_q), .sda(sda_s1), .nxt(st3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			wbyte_s1  <= write_byte;
			sda_s1    <= sda_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, cmd: CMD_NONE, delay: 10'd0, bits: 4'd0,
				shift: 8'd0,
				pins: '{scl_lvl: 1'b1, scl_drv: 1'b0, sda_lvl: 1'b1, sda_drv: 1'b0},
				ack: 1'b0, done: 1'b0, fin_read: 1'b0};
		end else if (adv) begin
			state_q <= st3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pins_s2  <= st3.pins;
			busy_s2  <= (st3.phase != PH_IDLE);
			done_s2  <= st3.done;
			rbyte_s2 <= st3.fin_read ? st3.shift : 8'd0;
			ack_s2   <= st3.ack;
		end
	end

	assign out_valid     = valid_s2;
	assign scl_level     = pins_s2.scl_lvl;
	assign scl_drive     = pins_s2.scl_drv;
	assign sda_out_level = pins_s2.sda_lvl;
	assign sda_drive     = pins_s2.sda_drv;
	assign busy_res      = busy_s2;
	assign done_res      = done_s2;
	assign read_byte     = rbyte_s2;
	assign ack_level     = ack_s2;

`ifndef ASSERT_OFF
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.phase))
		else $error("sequencer phase not one-hot");

	a_idle_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.delay == 10'd0)
		else $error("delay pending while idle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(done_s2 && busy_s2))
		else $error("done reported while still busy");

	a_rbyte_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rbyte_s2 != 8'd0) |-> done_s2)
		else $error("read byte without done");

	a_no_adv_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |-> !adv)
		else $error("result register overwritten while stalled");
`endif

endmodule

/* design/i2cbms_step.sv */
module i2cbms_step
	import i2cbms_pkg::*;
(
	input  seq_t       cur,
	input  logic [7:0] tpu,
	input  logic       sda,
	output seq_t       nxt
);

	logic [9:0] d1;
	logic [9:0] d2;
	logic [9:0] d3;
	logic [9:0] d4;
	logic [3:0] bits_dec;

	always_comb begin
		d1 = {2'b00, tpu};
		d2 = {1'b0, tpu, 1'b0};
		d3 = d1 + d2;
		d4 = {tpu, 2'b00};
		bits_dec = cur.bits - 4'd1;
		nxt = cur;
		if (cur.phase != PH_IDLE && cur.delay == 10'd0) begin
			case (cur.cmd)
				CMD_START: begin
					if (cur.phase == PH_S0) begin
						nxt.pins = '{scl_lvl: 1'b1, scl_drv: 1'b1, sda_lvl: 1'b1, sda_drv: 1'b1};
						nxt.delay = d2;
						nxt.phase = PH_S1;
					end else if (cur.phase == PH_S1) begin
						nxt.pins.sda_lvl = 1'b0;
						nxt.delay = d2;
						nxt.phase = PH_S2;
					end else begin
						nxt.pins.scl_lvl = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				CMD_STOP: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.sda_lvl = 1'b0;
						nxt.pins.sda_drv = 1'b1;
						nxt.pins.scl_lvl = 1'b1;
						nxt.delay = d2;
						nxt.phase = PH_S1;
					end else begin
						nxt.pins.sda_drv = 1'b0;
						nxt.pins.scl_drv = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.sda_drv = 1'b1;
						nxt.bits = BITS_PER_BYTE;
						nxt.phase = PH_S1;
					end else if (cur.phase == PH_S1) begin
						// zero-length units: no SCL pulses; SDA takes shift bit 0 and the write skips to its last phase
						if (tpu == 8'd0) begin
							nxt.pins.sda_lvl = cur.shift[0];
							nxt.pins.scl_lvl = 1'b0;
							nxt.shift = 8'd0;
							nxt.bits = 4'd0;
							nxt.delay = 10'd0;
							nxt.phase = PH_S3;
						end else begin
							nxt.pins.sda_lvl = cur.shift[7];
							nxt.shift = {cur.shift[6:0], 1'b0};
							nxt.pins.scl_lvl = 1'b1;
							nxt.delay = d4;
							nxt.phase = PH_S2;
						end
					end else if (cur.phase == PH_S2) begin
						nxt.pins.scl_lvl = 1'b0;
						nxt.bits = bits_dec;
						nxt.delay = d3;
						nxt.phase = (bits_dec != 4'd0) ? PH_S1 : PH_S3;
					end else begin
						nxt.pins.sda_drv = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				CMD_READ: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.sda_drv = 1'b0;
						nxt.bits = BITS_PER_BYTE;
						nxt.phase = PH_S1;
					end else if (cur.phase == PH_S1) begin
						nxt.delay = d1;
						nxt.phase = PH_S2;
					end else if (cur.phase == PH_S2) begin
						nxt.pins.scl_lvl = 1'b1;
						nxt.delay = SCL_HIGH_READ;
						nxt.phase = PH_S3;
					end else begin
						nxt.shift = {cur.shift[6:0], sda};
						nxt.pins.scl_lvl = 1'b0;
						nxt.bits = bits_dec;
						if (bits_dec != 4'd0) begin
							nxt.phase = PH_S1;
						end else begin
							nxt.phase = PH_IDLE;
							nxt.done = 1'b1;
							nxt.fin_read = 1'b1;
						end
					end
				end
				CMD_ACK_CHECK: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.scl_lvl = 1'b1;
						nxt.delay = d1;
						nxt.phase = PH_S1;
					end else begin
						nxt.ack = sda;
						nxt.pins.scl_lvl = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				CMD_SEND_ACK: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.sda_lvl = 1'b0;
						nxt.pins.sda_drv = 1'b1;
						nxt.delay = d1;
						nxt.phase = PH_S1;
					end else if (cur.phase == PH_S1) begin
						nxt.pins.scl_lvl = 1'b1;
						nxt.delay = d2;
						nxt.phase = PH_S2;
					end else begin
						nxt.pins.scl_lvl = 1'b0;
						nxt.pins.sda_drv = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				CMD_SEND_NACK: begin
					if (cur.phase == PH_S0) begin
						nxt.pins.sda_lvl = 1'b1;
						nxt.pins.sda_drv = 1'b1;
						nxt.pins.scl_lvl = 1'b1;
						nxt.delay = d1;
						nxt.phase = PH_S1;
					end else if (cur.phase == PH_S1) begin
						nxt.pins.scl_lvl = 1'b0;
						nxt.delay = d1;
						nxt.phase = PH_S2;
					end else begin
						nxt.pins.sda_drv = 1'b0;
						nxt.phase = PH_IDLE;
						nxt.done = 1'b1;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
					nxt.done = 1'b1;
				end
			endcase
		end
	end

endmodule
